// ----- rtl/moving_average_crossover_counter_assert.svh -----
// Assertion macros for the moving average crossover counter.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MOVING_AVERAGE_CROSSOVER_COUNTER_ASSERT_SVH
`define MOVING_AVERAGE_CROSSOVER_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MACC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define MACC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MACC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MACC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/macc_pkg.sv -----
// Shared constants, types and helper functions for the moving average crossover counter.
// No dependencies; every other RTL file except macc_ram and the assertion header uses it by scoped names.
package macc_pkg;

   localparam int MAX_WINDOW     = 64;
   localparam int SAMPLE_BITS    = 16;
   localparam int PTR_BITS       = $clog2(MAX_WINDOW);
   localparam int WIN_BITS       = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS       = SAMPLE_BITS + PTR_BITS;
   localparam int PROD_BITS      = SUM_BITS + WIN_BITS;
   localparam int COUNT_BITS     = 32;
   localparam int REL_BITS       = 2;
   localparam int CFG_BITS       = 7;
   localparam int CSR_INDEX_BITS = 1;

   // relation codes
   localparam logic [REL_BITS-1:0] REL_UNDET = 2'd0;
   localparam logic [REL_BITS-1:0] REL_ABOVE = 2'd1;
   localparam logic [REL_BITS-1:0] REL_BELOW = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_WINDOW = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_WINDOW  = 1'b1;

   localparam logic [CFG_BITS-1:0] SHORT_WINDOW_RESET = 7'd1;
   localparam logic [CFG_BITS-1:0] LONG_WINDOW_RESET  = 7'd2;

   // item held in the input stage
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   new_series;
      logic [PTR_BITS-1:0]    wp;
   } item_type;

   // effective window lengths
   typedef struct packed {
      logic [WIN_BITS-1:0] short_len;
      logic [WIN_BITS-1:0] long_len;
   } win_type;

   // samples leaving the two windows
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] short_old;
      logic [SAMPLE_BITS-1:0] long_old;
   } old_type;

   // history write
   typedef struct packed {
      logic                   en;
      logic [PTR_BITS-1:0]    addr;
      logic [SAMPLE_BITS-1:0] data;
   } wr_type;

   // clamp a window register into 1..hi
   function automatic logic [WIN_BITS-1:0] clamp_len(input logic [CFG_BITS-1:0] v,
                                                     input logic [WIN_BITS-1:0] hi);
      int vi;
      vi = int'(v);
      if (vi < 1) vi = 1;
      if (vi > int'(hi)) vi = int'(hi);
      return WIN_BITS'(vi);
   endfunction

   // ring position len entries behind wp
   function automatic logic [PTR_BITS-1:0] ring_back(input logic [PTR_BITS-1:0] wp,
                                                     input logic [WIN_BITS-1:0] len);
      int d;
      d = int'(wp) - int'(len);
      if (d < 0) d = d + MAX_WINDOW;
      return PTR_BITS'(d);
   endfunction

   // ring successor
   function automatic logic [PTR_BITS-1:0] ring_next(input logic [PTR_BITS-1:0] wp);
      logic [PTR_BITS-1:0] r;
      if (int'(wp) == MAX_WINDOW - 1) r = '0;
      else r = wp + PTR_BITS'(1);
      return r;
   endfunction

endpackage

// ----- rtl/macc_req_if.sv -----
// Sample channel: valid/ready handshake carrying one sample per transaction.
// Depends on macc_pkg.
interface macc_req_if;
   logic                             valid;
   logic                             ready;
   logic [macc_pkg::SAMPLE_BITS-1:0] sample;
   logic                             new_series;

   modport source (output valid, output sample, output new_series, input ready);
   modport sink (input valid, input sample, input new_series, output ready);
endinterface

// ----- rtl/macc_rsp_if.sv -----
// Result channel: valid/ready handshake carrying one crossover result per transaction.
// Depends on macc_pkg.
interface macc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            averages_valid;
   logic [macc_pkg::REL_BITS-1:0]   relation;
   logic                            crossed;
   logic [macc_pkg::COUNT_BITS-1:0] crossing_count;

   modport source (output valid, output averages_valid, output relation, output crossed,
                   output crossing_count, input ready);
   modport sink (input valid, input averages_valid, input relation, input crossed,
                 input crossing_count, output ready);
endinterface

// ----- rtl/moving_average_crossover_counter.sv -----
// Dual moving average crossover counter. One sample is accepted per clock; its result passes
// through the input stage, then the result register. Throughput is one transaction per cycle,
// held back only by rsp.ready. The sample history is a 64-entry RAM with two registered read
// ports, read at acceptance, so the whole sum, cross-multiply and compare fits in the single
// compute stage. Any CSR write starts a new series.
// Depends on macc_pkg, macc_req_if, macc_rsp_if, macc_ram and macc_core.
module moving_average_crossover_counter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [macc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [macc_pkg::CFG_BITS-1:0]         csr_write_data,
   macc_req_if.sink                              req,
   macc_rsp_if.source                            rsp
);

   logic [macc_pkg::CFG_BITS-1:0]    short_window_ff;
   logic [macc_pkg::CFG_BITS-1:0]    long_window_ff;
   macc_pkg::win_type                win;

   logic [macc_pkg::PTR_BITS-1:0]    ptr_ff;
   logic                             stage_valid_ff;
   macc_pkg::item_type               stage_item_ff, item_in;
   logic                             byp_s_ff, byp_l_ff;
   logic [macc_pkg::SAMPLE_BITS-1:0] byp_data_ff;

   logic                             accept;
   logic                             take;
   logic [macc_pkg::PTR_BITS-1:0]    rd_addr_s, rd_addr_l;
   logic [macc_pkg::SAMPLE_BITS-1:0] rd_data_s, rd_data_l;
   macc_pkg::old_type                old;
   macc_pkg::wr_type                 wr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         short_window_ff <= macc_pkg::SHORT_WINDOW_RESET;
         long_window_ff  <= macc_pkg::LONG_WINDOW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            macc_pkg::CSR_SHORT_WINDOW: short_window_ff <= csr_write_data;
            macc_pkg::CSR_LONG_WINDOW:  long_window_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // effective window lengths
   always_comb begin
      win.long_len  = macc_pkg::clamp_len(long_window_ff,
                                          macc_pkg::WIN_BITS'(macc_pkg::MAX_WINDOW));
      win.short_len = macc_pkg::clamp_len(short_window_ff, win.long_len);
   end

   // input handshake: the stage frees up as its item moves on
   assign req.ready = !stage_valid_ff || take;
   assign accept    = req.valid && req.ready;

   // history slot for the incoming sample and the two slots leaving the windows
   always_comb begin
      item_in.sample     = req.sample;
      item_in.new_series = req.new_series;
      item_in.wp         = req.new_series ? '0 : ptr_ff;
      rd_addr_s          = macc_pkg::ring_back(item_in.wp, win.short_len);
      rd_addr_l          = macc_pkg::ring_back(item_in.wp, win.long_len);
   end

   // input stage, write pointer and same-edge write forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         ptr_ff         <= '0;
      end else begin
         if (accept) begin
            stage_valid_ff <= 1'b1;
         end else if (take) begin
            stage_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            ptr_ff <= '0;
         end else if (accept) begin
            ptr_ff <= macc_pkg::ring_next(item_in.wp);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff <= item_in;
         byp_s_ff      <= wr.en && (wr.addr == rd_addr_s);
         byp_l_ff      <= wr.en && (wr.addr == rd_addr_l);
         byp_data_ff   <= wr.data;
      end
   end

   macc_ram #(
      .WIDTH (macc_pkg::SAMPLE_BITS),
      .DEPTH (macc_pkg::MAX_WINDOW)
   ) u_history (
      .clock     (clock),
      .wr_en     (wr.en),
      .wr_addr   (wr.addr),
      .wr_data   (wr.data),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_s),
      .rd_addr_b (rd_addr_l),
      .rd_data_a (rd_data_s),
      .rd_data_b (rd_data_l)
   );

   // pick forwarded data over the RAM where the slot was written on the read edge
   always_comb begin
      old.short_old = byp_s_ff ? byp_data_ff : rd_data_s;
      old.long_old  = byp_l_ff ? byp_data_ff : rd_data_l;
   end

   macc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_clear  (csr_write_enable),
      .item_valid (stage_valid_ff),
      .item       (stage_item_ff),
      .win        (win),
      .old        (old),
      .take       (take),
      .wr         (wr),
      .rsp        (rsp)
   );

endmodule

// ----- rtl/macc_ram.sv -----
// Generic simple dual-read RAM: one write port, two registered read ports.
// Standalone; read returns the contents from before a same-edge write.
module macc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

// ----- rtl/macc_core.sv -----
// Compute stage: running sums, exact average compare, relation tracking, result register.
// Depends on macc_pkg, macc_rsp_if and the assertion macro header.
`include "moving_average_crossover_counter_assert.svh"

module macc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_clear,
   input  logic                item_valid,
   input  macc_pkg::item_type  item,
   input  macc_pkg::win_type   win,
   input  macc_pkg::old_type   old,
   output logic                take,
   output macc_pkg::wr_type    wr,
   macc_rsp_if.source          rsp
);

   logic [macc_pkg::WIN_BITS-1:0]   fill_ff, fill_in;
   logic [macc_pkg::SUM_BITS-1:0]   short_sum_ff, short_sum_in;
   logic [macc_pkg::SUM_BITS-1:0]   long_sum_ff, long_sum_in;
   logic [macc_pkg::REL_BITS-1:0]   rel_ff, rel_in;
   logic [macc_pkg::COUNT_BITS-1:0] count_ff, count_in;

   logic                            rsp_valid_ff;
   logic                            rsp_avg_ff, avg_in;
   logic [macc_pkg::REL_BITS-1:0]   rsp_rel_ff, rel_out_in;
   logic                            rsp_crossed_ff, crossed_in;
   logic [macc_pkg::COUNT_BITS-1:0] rsp_count_ff;

   // the item moves on when the result register is free or being drained
   assign take = item_valid && (!rsp_valid_ff || rsp.ready);

   // history write of the current sample
   always_comb begin
      wr.en   = take;
      wr.addr = item.wp;
      wr.data = item.sample;
   end

   // sums, fill and comparison for the item in the stage
   always_comb begin
      logic [macc_pkg::WIN_BITS-1:0]    fill;
      logic [macc_pkg::SUM_BITS-1:0]    ssum, lsum;
      logic [macc_pkg::REL_BITS-1:0]    rel;
      logic [macc_pkg::COUNT_BITS-1:0]  cnt;
      logic [macc_pkg::SAMPLE_BITS-1:0] old_s, old_l;
      logic                             first;
      logic [macc_pkg::PROD_BITS-1:0]   a, b;

      fill  = item.new_series ? '0 : fill_ff;
      ssum  = item.new_series ? '0 : short_sum_ff;
      lsum  = item.new_series ? '0 : long_sum_ff;
      rel   = item.new_series ? macc_pkg::REL_UNDET : rel_ff;
      cnt   = item.new_series ? '0 : count_ff;
      old_s = (fill >= win.short_len) ? old.short_old : '0;
      old_l = (fill >= win.long_len) ? old.long_old : '0;

      short_sum_in = ssum + macc_pkg::SUM_BITS'(item.sample) - macc_pkg::SUM_BITS'(old_s);
      long_sum_in  = lsum + macc_pkg::SUM_BITS'(item.sample) - macc_pkg::SUM_BITS'(old_l);

      first   = 1'b0;
      fill_in = fill;
      if (fill < win.long_len) begin
         fill_in = fill + macc_pkg::WIN_BITS'(1);
         first   = (fill_in == win.long_len);
      end
      avg_in = (fill_in >= win.long_len);

      // exact compare: short_sum * L against long_sum * S
      a = macc_pkg::PROD_BITS'(short_sum_in) * macc_pkg::PROD_BITS'(win.long_len);
      b = macc_pkg::PROD_BITS'(long_sum_in) * macc_pkg::PROD_BITS'(win.short_len);

      rel_in     = rel;
      crossed_in = 1'b0;
      if (avg_in) begin
         if (first) begin
            rel_in = (a > b) ? macc_pkg::REL_ABOVE :
                     ((a < b) ? macc_pkg::REL_BELOW : macc_pkg::REL_UNDET);
         end else if (rel == macc_pkg::REL_ABOVE && a < b) begin
            rel_in     = macc_pkg::REL_BELOW;
            crossed_in = 1'b1;
         end else if (rel == macc_pkg::REL_BELOW && a > b) begin
            rel_in     = macc_pkg::REL_ABOVE;
            crossed_in = 1'b1;
         end
      end
      rel_out_in = avg_in ? rel_in : macc_pkg::REL_UNDET;

      // saturating crossing count
      count_in = cnt;
      if (crossed_in && cnt != '1) count_in = cnt + macc_pkg::COUNT_BITS'(1);
   end

   // series state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         short_sum_ff <= '0;
         long_sum_ff  <= '0;
         rel_ff       <= macc_pkg::REL_UNDET;
         count_ff     <= '0;
      end else begin
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_clear) begin
            fill_ff      <= '0;
            short_sum_ff <= '0;
            long_sum_ff  <= '0;
            rel_ff       <= macc_pkg::REL_UNDET;
            count_ff     <= '0;
         end else if (take) begin
            fill_ff      <= fill_in;
            short_sum_ff <= short_sum_in;
            long_sum_ff  <= long_sum_in;
            rel_ff       <= rel_in;
            count_ff     <= count_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_avg_ff     <= avg_in;
         rsp_rel_ff     <= rel_out_in;
         rsp_crossed_ff <= crossed_in;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.averages_valid = rsp_avg_ff;
   assign rsp.relation       = rsp_rel_ff;
   assign rsp.crossed        = rsp_crossed_ff;
   assign rsp.crossing_count = rsp_count_ff;

   `MACC_ASSERT_IMP(a_not_full_quiet, clock, reset, rsp_valid_ff && !rsp_avg_ff, rsp_rel_ff == macc_pkg::REL_UNDET && !rsp_crossed_ff, "relation or crossing reported before windows are full")
   `MACC_ASSERT_IMP(a_cross_has_rel, clock, reset, rsp_valid_ff && rsp_crossed_ff, rsp_rel_ff != macc_pkg::REL_UNDET && rsp_count_ff != '0, "crossing without relation or count")
   `MACC_ASSERT_IMP(a_fill_bounded, clock, reset, 1'b1, fill_ff <= win.long_len, "fill count beyond long window")
   `MACC_ASSERT_NEXT(a_count_held, clock, reset, !take && !csr_clear, $stable(count_ff) && $stable(rel_ff), "series state changed without a transaction")

endmodule

// ----- verif/tb.sv -----
// Testbench for moving_average_crossover_counter: random-gapped sample transactions, a
// transaction-level predictor of the crossover results and a field-by-field result check.
// Depends on macc_pkg, macc_req_if, macc_rsp_if and the RTL top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 160;
   localparam int TOTAL_SAMPLES  = 1150;
   localparam int MAX_REPORTS    = 10;
   localparam int SETTLE_CYCLES  = 3;

   // one result transaction
   typedef struct packed {
      logic                            averages_valid;
      logic [macc_pkg::REL_BITS-1:0]   relation;
      logic                            crossed;
      logic [macc_pkg::COUNT_BITS-1:0] crossing_count;
   } crossover_type;

   // sample stream shapes
   typedef enum int {SHAPE_NOISE, SHAPE_WAVE, SHAPE_RAILS, SHAPE_FLAT} shape_type;

   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                csr_write_enable = 1'b0;
   logic [macc_pkg::CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [macc_pkg::CFG_BITS-1:0]       csr_write_data   = '0;

   macc_req_if req_if ();
   macc_rsp_if rsp_if ();

   moving_average_crossover_counter i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_if),
      .rsp              (rsp_if)
   );

   // predictor state
   logic [macc_pkg::CFG_BITS-1:0]    short_cfg = macc_pkg::SHORT_WINDOW_RESET;
   logic [macc_pkg::CFG_BITS-1:0]    long_cfg  = macc_pkg::LONG_WINDOW_RESET;
   logic [macc_pkg::SAMPLE_BITS-1:0] history_model [macc_pkg::MAX_WINDOW];
   logic [macc_pkg::PTR_BITS-1:0]    head_model  = '0;
   logic [macc_pkg::WIN_BITS-1:0]    fill_model  = '0;
   logic [31:0]                      short_total = '0;
   logic [31:0]                      long_total  = '0;
   logic [macc_pkg::REL_BITS-1:0]    trend_model = macc_pkg::REL_UNDET;
   logic [macc_pkg::COUNT_BITS-1:0]  cross_total = '0;

   crossover_type pending_crossovers [$];
   int            failures     = 0;
   int            idle_cycles  = 0;
   int            samples_sent = 0;
   int            hold_left    = 0;
   bit            calm         = 1'b0;
   bit            hold_armed   = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   // window register to effective length in 1..top
   function automatic logic [macc_pkg::WIN_BITS-1:0] bounded_len(
         input logic [macc_pkg::CFG_BITS-1:0] v,
         input logic [macc_pkg::WIN_BITS-1:0] top);
      logic [macc_pkg::WIN_BITS-1:0] r;
      if (v == '0) r = macc_pkg::WIN_BITS'(1);
      else if (v > top) r = top;
      else r = v[macc_pkg::WIN_BITS-1:0];
      return r;
   endfunction

   function automatic void restart_series();
      head_model  = '0;
      fill_model  = '0;
      short_total = '0;
      long_total  = '0;
      trend_model = macc_pkg::REL_UNDET;
      cross_total = '0;
   endfunction

   // advance both windows by one sample and work out the result it causes
   function automatic crossover_type predict_crossover(
         input logic [macc_pkg::SAMPLE_BITS-1:0] x,
         input logic fresh);
      logic [macc_pkg::WIN_BITS-1:0]    lw, sw;
      logic [macc_pkg::SAMPLE_BITS-1:0] leave_s, leave_l;
      logic [63:0]                      scaled_short, scaled_long;
      logic                             first;
      crossover_type                    r;
      lw = bounded_len(long_cfg, macc_pkg::WIN_BITS'(macc_pkg::MAX_WINDOW));
      sw = bounded_len(short_cfg, lw);
      if (fresh) restart_series();
      // only samples written in this series ever leave a window
      leave_s = (fill_model >= sw) ?
                history_model[macc_pkg::PTR_BITS'(head_model - sw)] : '0;
      leave_l = (fill_model >= lw) ?
                history_model[macc_pkg::PTR_BITS'(head_model - lw)] : '0;
      short_total = short_total + x - leave_s;
      long_total  = long_total + x - leave_l;
      history_model[head_model] = x;
      head_model = head_model + 1'b1;
      first = 1'b0;
      if (fill_model < lw) begin
         fill_model = fill_model + 1'b1;
         first = (fill_model == lw);
      end
      r = '0;
      r.averages_valid = (fill_model >= lw);
      if (r.averages_valid) begin
         // exact compare of averages by cross-multiplying
         scaled_short = 64'(short_total) * 64'(lw);
         scaled_long  = 64'(long_total) * 64'(sw);
         if (first) begin
            if (scaled_short > scaled_long) trend_model = macc_pkg::REL_ABOVE;
            else if (scaled_short < scaled_long) trend_model = macc_pkg::REL_BELOW;
            else trend_model = macc_pkg::REL_UNDET;
         end else if (trend_model == macc_pkg::REL_ABOVE && scaled_short < scaled_long) begin
            trend_model = macc_pkg::REL_BELOW;
            r.crossed = 1'b1;
         end else if (trend_model == macc_pkg::REL_BELOW && scaled_short > scaled_long) begin
            trend_model = macc_pkg::REL_ABOVE;
            r.crossed = 1'b1;
         end
         if (r.crossed && cross_total != '1) cross_total = cross_total + 1'b1;
         r.relation = trend_model;
      end
      r.crossing_count = cross_total;
      return r;
   endfunction

   function automatic void flag_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
   endfunction

   // monitor: register writes, sample and result transactions, watchdog
   always @(posedge clock) begin : monitor
      crossover_type seen, want;
      if (!reset) begin
         idle_cycles = idle_cycles + 1;
         if (csr_write_enable) begin
            if (csr_index == macc_pkg::CSR_SHORT_WINDOW) short_cfg = csr_write_data;
            else if (csr_index == macc_pkg::CSR_LONG_WINDOW) long_cfg = csr_write_data;
            restart_series();
            idle_cycles = 0;
         end
         if (req_if.valid && req_if.ready) begin
            pending_crossovers.push_back(predict_crossover(req_if.sample, req_if.new_series));
            idle_cycles = 0;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            idle_cycles = 0;
            seen.averages_valid = rsp_if.averages_valid;
            seen.relation       = rsp_if.relation;
            seen.crossed        = rsp_if.crossed;
            seen.crossing_count = rsp_if.crossing_count;
            if (pending_crossovers.size() == 0) begin
               flag_failure($sformatf("unexpected result valid=%0b rel=%0d crossed=%0b count=%0d",
                  seen.averages_valid, seen.relation, seen.crossed, seen.crossing_count));
            end else begin
               want = pending_crossovers.pop_front();
               if (seen.averages_valid !== want.averages_valid ||
                   seen.relation !== want.relation ||
                   seen.crossed !== want.crossed ||
                   seen.crossing_count !== want.crossing_count) begin
                  flag_failure($sformatf(
                     "expected valid=%0b rel=%0d crossed=%0b count=%0d, got %0b %0d %0b %0d",
                     want.averages_valid, want.relation, want.crossed, want.crossing_count,
                     seen.averages_valid, seen.relation, seen.crossed, seen.crossing_count));
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // result receiver: random stalls, plus a long hold-off when armed
   always @(negedge clock) begin
      if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left  = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_if.ready <= calm || ($urandom_range(99) >= 7);
      end
   end

   // one sample transaction; entered and left at a falling edge
   task automatic send_sample(input logic [macc_pkg::SAMPLE_BITS-1:0] value,
                              input logic fresh);
      if (!calm && $urandom_range(99) < 7) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.sample     <= value;
      req_if.new_series <= fresh;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      samples_sent++;
      @(negedge clock);
   endtask

   // stop offering and wait until every predicted result has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_crossovers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [macc_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [macc_pkg::CFG_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
   endtask

   // both registers, in random order, only while the block is idle
   task automatic set_windows(input logic [macc_pkg::CFG_BITS-1:0] short_len,
                              input logic [macc_pkg::CFG_BITS-1:0] long_len);
      wait_drained();
      if ($urandom_range(1)) begin
         write_csr(macc_pkg::CSR_SHORT_WINDOW, short_len);
         write_csr(macc_pkg::CSR_LONG_WINDOW, long_len);
      end else begin
         write_csr(macc_pkg::CSR_LONG_WINDOW, long_len);
         write_csr(macc_pkg::CSR_SHORT_WINDOW, short_len);
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [macc_pkg::SAMPLE_BITS-1:0] shaped_sample(
         input shape_type shape, input int step,
         input int base, input int swing,
         input int period);
      int t, v;
      case (shape)
         SHAPE_NOISE: v = $urandom_range(65535);
         SHAPE_WAVE: begin
            // triangle wave with a little noise, so averages cross repeatedly
            t = step % period;
            if (t > period / 2) t = period - t;
            v = base - swing / 2 + (swing * 2 * t) / period + $urandom_range(swing / 16);
         end
         SHAPE_RAILS: v = $urandom_range(1) ? 65535 : 0;
         default: v = ($urandom_range(15) == 0) ? $urandom_range(65535) : base;
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return macc_pkg::SAMPLE_BITS'(v);
   endfunction

   // a run of samples of one random shape, with rare new_series restarts inside it
   task automatic send_series(input int count, input int window, input logic fresh_first);
      shape_type shape;
      int        pick, base, swing, period;
      pick = $urandom_range(9);
      if (pick < 6) shape = SHAPE_WAVE;
      else if (pick < 8) shape = SHAPE_NOISE;
      else if (pick == 8) shape = SHAPE_RAILS;
      else shape = SHAPE_FLAT;
      base   = $urandom_range(65535);
      swing  = $urandom_range(65535);
      period = $urandom_range(4 * window + 4, 2);
      for (int i = 0; i < count; i++) begin
         send_sample(shaped_sample(shape, i, base, swing, period),
                     (i == 0) ? fresh_first : ($urandom_range(49) == 0));
      end
   endtask

   // reset windows (1 and 2): sticky initial tie, then crossings both ways
   task automatic test_reset_windows();
      send_sample(16'd0, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'd10, 1'b1);
      send_sample(16'd20, 1'b0);
      send_sample(16'd5, 1'b0);
      send_sample(16'd5, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'd0, 1'b0);
   endtask

   // small windows, out-of-range registers and windows that never fill
   task automatic test_directed_windows();
      set_windows(7'd3, 7'd5);
      send_sample(16'd100, 1'b0);
      send_sample(16'd200, 1'b0);
      send_sample(16'd300, 1'b0);
      send_sample(16'd400, 1'b0);
      send_sample(16'd500, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      // zero registers clamp to one sample each: always a tie
      set_windows(7'd0, 7'd0);
      send_sample(16'd7, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'd0, 1'b0);
      // short register above long clamps to long
      set_windows(7'd127, 7'd4);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'd1, 1'b0);
      send_sample(16'hAAAA, 1'b0);
      send_sample(16'h5555, 1'b0);
   endtask

   // largest windows, including registers past the maximum
   task automatic test_widest_windows();
      set_windows(7'd127, 7'd127);
      send_series(70, macc_pkg::MAX_WINDOW, 1'b0);
      set_windows(7'd5, 7'd64);
      send_series(150, macc_pkg::MAX_WINDOW, 1'b0);
      set_windows(7'd63, 7'd64);
      send_series(80, macc_pkg::MAX_WINDOW, 1'b0);
   endtask

   // receiver holds off while samples keep coming; then a mid-series drain
   task automatic test_backpressure();
      set_windows(7'd2, 7'd6);
      calm = 1'b1;
      hold_armed = 1'b1;
      send_series(120, 6, 1'b0);
      calm = 1'b0;
      send_series(30, 6, 1'b1);
      wait_drained();
      send_series(30, 6, 1'b0);
   endtask

   // random window settings, mostly short, with random series content
   task automatic test_random_series();
      int lw, sw, pick;
      while (samples_sent < TOTAL_SAMPLES) begin
         pick = $urandom_range(19);
         if (pick == 0) lw = 0;
         else if (pick == 1) lw = $urandom_range(127, 65);
         else if (pick == 2) lw = macc_pkg::MAX_WINDOW;
         else lw = $urandom_range(12, 1);
         pick = $urandom_range(9);
         if (pick == 0) sw = 0;
         else if (pick == 1) sw = 127;
         else sw = $urandom_range(lw + 2, 0);
         if ($urandom_range(3) == 0) begin
            // same windows, restart by new_series only
            send_series($urandom_range(60, 20), (lw < 1) ? 1 : lw, 1'b1);
         end else begin
            set_windows(macc_pkg::CFG_BITS'(sw), macc_pkg::CFG_BITS'(lw));
            send_series($urandom_range(60, 20), (lw < 1) ? 1 : lw,
                        1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < macc_pkg::MAX_WINDOW; i++) history_model[i] = '0;
      req_if.valid      = 1'b0;
      req_if.sample     = '0;
      req_if.new_series = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_windows();
      test_directed_windows();
      test_widest_windows();
      test_backpressure();
      test_random_series();
      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0 && pending_crossovers.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
